// File: hw/rtl/ilir_pkg.sv
// Package with the request, response and cell command types of the indexed list.
package ilir_pkg;

  localparam int unsigned IDX_W = 6;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 7;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_BOUNDS = 2'd1,
    ERR_FULL   = 2'd2
  } err_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    err_e             error;
    logic [CNT_W-1:0] count;
    logic             is_empty;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_down;
  } cell_cmd_t;

endpackage

// File: hw/rtl/ilir_stream_if.sv
// Valid/ready channel interface carrying one payload per request.
interface ilir_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/ilir_cell.sv
// One storage cell of the list chain, holding the entry at a fixed position.
module ilir_cell #(
  parameter int unsigned POS_W  = 6,
  parameter int unsigned POS    = 0,
  parameter int unsigned WORD_W = 32
) (
  input  logic                  clk_i,
  input  ilir_pkg::cell_cmd_t   cmd_i,
  input  logic [POS_W-1:0]      pos_i,
  input  logic [WORD_W-1:0]     word_i,
  input  logic [WORD_W-1:0]     left_i,
  input  logic [WORD_W-1:0]     right_i,
  output logic [WORD_W-1:0]     data_o,
  output logic [WORD_W-1:0]     rd_o
);

  logic [WORD_W-1:0] data_q;
  logic [WORD_W-1:0] data_d;
  logic              hit;
  logic              above;

  assign hit   = (pos_i == POS_W'(POS));
  assign above = (POS_W'(POS) > pos_i);

  always_comb begin
    data_d = data_q;
    if (cmd_i.load && hit) begin
      data_d = word_i;
    end else if (cmd_i.shift_up && above) begin
      data_d = left_i;
    end else if (cmd_i.shift_down && (above || hit)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = hit ? data_q : '0;

endmodule

// File: hw/rtl/indexed_list_insert_remove.sv
// Top level of the indexed list: request decode, cell chain and response register.
//
// Requests arrive on req_i and carry an op, an index and a value. Append puts
// the value after the last entry, insert places it at the index and moves later
// entries up, read returns the entry at the index, and remove drops it and moves
// later entries down. Each request yields exactly one response on rsp_o with the
// read word, an error code, the new count and an empty flag.
// Every entry lives in its own cell of a chain; the cells above the index, and on
// remove the cell at it, shift toward or away from their neighbor in the same cycle.
// A response appears in the cycle after its request is accepted, and while the
// receiver does not stall, one request can be accepted in every cycle.
// The response register holds its value while the receiver stalls; a new request
// is accepted only when that register is empty or is drained in the same cycle.
// Reset empties the list and the response register; the contents of the cells
// are not cleared, since only written positions can ever be read.
module indexed_list_insert_remove #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ilir_stream_if.sink   req_i,
  ilir_stream_if.source rsp_o
);

  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned PW    = $clog2(CAPACITY);
  localparam int unsigned CMP_W = (CW > ilir_pkg::IDX_W) ? CW : ilir_pkg::IDX_W;

  logic [CW-1:0]         count_q;
  logic [CW-1:0]         count_d;
  logic                  rsp_valid_q;
  ilir_pkg::rsp_t        rsp_q;
  ilir_pkg::rsp_t        rsp_d;
  ilir_pkg::cell_cmd_t   cmd;
  logic [PW-1:0]         pos;
  logic [WORD_WIDTH-1:0] word;
  logic                  accept;
  logic                  full;
  logic                  oob;
  logic [WORD_WIDTH-1:0] rd_word;
  logic [WORD_WIDTH-1:0] cell_data [CAPACITY];
  logic [WORD_WIDTH-1:0] cell_rd [CAPACITY];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (count_q == CW'(CAPACITY));
  assign oob         = CMP_W'(req_i.payload.index) >= CMP_W'(count_q);
  assign word        = WORD_WIDTH'(req_i.payload.value);

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  always_comb begin
    cmd              = '0;
    pos              = PW'(req_i.payload.index);
    count_d          = count_q;
    rsp_d.read_value = '0;
    rsp_d.error      = ilir_pkg::ERR_OK;
    case (req_i.payload.op)
      ilir_pkg::OP_APPEND: begin
        pos = PW'(count_q);
        if (full) begin
          rsp_d.error = ilir_pkg::ERR_FULL;
        end else begin
          cmd.load = 1'b1;
          count_d  = count_q + 1'b1;
        end
      end
      ilir_pkg::OP_INSERT: begin
        if (oob) begin
          rsp_d.error = ilir_pkg::ERR_BOUNDS;
        end else if (full) begin
          rsp_d.error = ilir_pkg::ERR_FULL;
        end else begin
          cmd.load     = 1'b1;
          cmd.shift_up = 1'b1;
          count_d      = count_q + 1'b1;
        end
      end
      ilir_pkg::OP_READ: begin
        if (oob) begin
          rsp_d.error = ilir_pkg::ERR_BOUNDS;
        end else begin
          rsp_d.read_value = ilir_pkg::VAL_W'(rd_word);
        end
      end
      ilir_pkg::OP_REMOVE: begin
        if (oob) begin
          rsp_d.error = ilir_pkg::ERR_BOUNDS;
        end else begin
          cmd.shift_down = 1'b1;
          count_d        = count_q - 1'b1;
        end
      end
      default: begin
        rsp_d.error = ilir_pkg::ERR_OK;
      end
    endcase
    if (!accept) begin
      cmd     = '0;
      count_d = count_q;
    end
    rsp_d.count    = ilir_pkg::CNT_W'(count_d);
    rsp_d.is_empty = (count_d == '0);
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_WIDTH-1:0] left;
    logic [WORD_WIDTH-1:0] right;
    if (g == 0) begin : g_first
      assign left = cell_data[g];
    end else begin : g_left
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_right
      assign right = cell_data[g+1];
    end
    ilir_cell #(
      .POS_W  (PW),
      .POS    (g),
      .WORD_W (WORD_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (pos),
      .word_i  (word),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g]),
      .rd_o    (cell_rd[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("Entry count exceeds the capacity.");

  a_accept_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_valid_q)
    else $error("An accepted request left no response.");

  a_rsp_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (rsp_q.count == ilir_pkg::CNT_W'(count_q)))
    else $error("Response count differs from the stored count.");

  a_full_only_at_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_q.error == ilir_pkg::ERR_FULL)) |-> full)
    else $error("Full error reported while the list has room.");

endmodule

// File: sim/indexed_list_insert_remove_test.sv
// Self-checking testbench for the indexed list with a queue-based predictor.
`timescale 1ns / 1ps

module indexed_list_insert_remove_test;
  import ilir_pkg::*;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned RANDOM_ITEMS = 626;
  localparam int unsigned HOLDOFF_AT   = 300;
  localparam int unsigned HOLDOFF_LEN  = 400;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned PRINT_LIMIT  = 30;
  localparam int unsigned N_DIRECTED   = 24;

  typedef enum {TREND_GROW, TREND_FULL, TREND_SHRINK, TREND_MIX} trend_e;

  typedef struct {
    logic known;
    rsp_t rsp;
  } pinned_t;

  typedef struct {
    req_t req;
    logic known;
    rsp_t rsp;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ilir_stream_if #(.payload_t(req_t)) req_if ();
  ilir_stream_if #(.payload_t(rsp_t)) rsp_if ();

  indexed_list_insert_remove #(
    .CAPACITY  (CAPACITY),
    .WORD_WIDTH(VAL_W)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  logic [VAL_W-1:0] list_q[$];
  rsp_t             due_rsp_q[$];
  pinned_t          pinned_rsp_q[$];
  int unsigned      accepted_reqs = 0;
  int unsigned      seen_rsps = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      fail_count = 0;
  int unsigned      burst_left = 0;

  dir_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{'{OP_READ,   6'd0,  32'h0000_0000}, 1'b1, '{32'h0, ERR_BOUNDS, 7'd0, 1'b1}},
    '{'{OP_REMOVE, 6'd0,  32'h0000_0000}, 1'b1, '{32'h0, ERR_BOUNDS, 7'd0, 1'b1}},
    '{'{OP_INSERT, 6'd0,  32'h0000_0001}, 1'b1, '{32'h0, ERR_BOUNDS, 7'd0, 1'b1}},
    '{'{OP_APPEND, 6'd63, 32'hFFFF_FFFF}, 1'b1, '{32'h0, ERR_OK, 7'd1, 1'b0}},
    '{'{OP_READ,   6'd0,  32'h0000_0000}, 1'b1, '{32'hFFFF_FFFF, ERR_OK, 7'd1, 1'b0}},
    '{'{OP_APPEND, 6'd0,  32'h0000_0000}, 1'b1, '{32'h0, ERR_OK, 7'd2, 1'b0}},
    '{'{OP_INSERT, 6'd0,  32'hA5A5_5A5A}, 1'b0, '0},
    '{'{OP_INSERT, 6'd2,  32'h1234_5678}, 1'b0, '0},
    '{'{OP_INSERT, 6'd4,  32'hDEAD_BEEF}, 1'b1, '{32'h0, ERR_BOUNDS, 7'd4, 1'b0}},
    '{'{OP_READ,   6'd63, 32'h0000_0000}, 1'b1, '{32'h0, ERR_BOUNDS, 7'd4, 1'b0}},
    '{'{OP_READ,   6'd3,  32'hFFFF_FFFF}, 1'b0, '0},
    '{'{OP_READ,   6'd0,  32'h0000_0000}, 1'b0, '0},
    '{'{OP_REMOVE, 6'd63, 32'h0000_0000}, 1'b1, '{32'h0, ERR_BOUNDS, 7'd4, 1'b0}},
    '{'{OP_REMOVE, 6'd3,  32'h0000_0000}, 1'b0, '0},
    '{'{OP_REMOVE, 6'd0,  32'h0000_0000}, 1'b0, '0},
    '{'{OP_READ,   6'd1,  32'h0000_0000}, 1'b0, '0},
    '{'{OP_INSERT, 6'd1,  32'h8000_0001}, 1'b0, '0},
    '{'{OP_REMOVE, 6'd1,  32'h0000_0000}, 1'b0, '0},
    '{'{OP_REMOVE, 6'd0,  32'h0000_0000}, 1'b0, '0},
    '{'{OP_REMOVE, 6'd0,  32'h0000_0000}, 1'b1, '{32'h0, ERR_OK, 7'd0, 1'b1}},
    '{'{OP_READ,   6'd0,  32'h0000_0000}, 1'b1, '{32'h0, ERR_BOUNDS, 7'd0, 1'b1}},
    '{'{OP_APPEND, 6'd42, 32'h5A5A_A5A5}, 1'b1, '{32'h0, ERR_OK, 7'd1, 1'b0}},
    '{'{OP_REMOVE, 6'd0,  32'h0000_0000}, 1'b1, '{32'h0, ERR_OK, 7'd0, 1'b1}},
    '{'{OP_REMOVE, 6'd0,  32'h0000_0000}, 1'b1, '{32'h0, ERR_BOUNDS, 7'd0, 1'b1}}
  };

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic rsp_t list_apply(input req_t r);
    rsp_t        rsp;
    int unsigned fill;
    rsp = '0;
    rsp.error = ERR_OK;
    fill = list_q.size();
    if (r.op == OP_APPEND) begin
      if (fill >= CAPACITY) rsp.error = ERR_FULL;
      else list_q.push_back(r.value);
    end else if (r.index >= fill) begin
      rsp.error = ERR_BOUNDS;
    end else begin
      case (r.op)
        OP_INSERT: begin
          if (fill >= CAPACITY) rsp.error = ERR_FULL;
          else list_q.insert(r.index, r.value);
        end
        OP_READ: rsp.read_value = list_q[r.index];
        default: list_q.delete(r.index);
      endcase
    end
    rsp.count = CNT_W'(list_q.size());
    rsp.is_empty = (list_q.size() == 0);
    return rsp;
  endfunction

  function automatic req_t make_request(input trend_e trend);
    req_t        r;
    int unsigned fill;
    int unsigned pick;
    fill = list_q.size();
    r.value = $urandom();
    r.index = IDX_W'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    case (trend)
      TREND_GROW: begin
        r.op = pick < 50 ? OP_APPEND : pick < 80 ? OP_INSERT : pick < 90 ? OP_READ : OP_REMOVE;
      end
      TREND_FULL: begin
        r.op = pick < 40 ? OP_APPEND : pick < 80 ? OP_INSERT : OP_READ;
      end
      TREND_SHRINK: begin
        r.op = pick < 55 ? OP_REMOVE : pick < 75 ? OP_READ : pick < 88 ? OP_APPEND : OP_INSERT;
      end
      default: r.op = op_e'($urandom_range(0, 3));
    endcase
    // Most requests aim inside the list; the rest keep their random index.
    if (fill > 0 && $urandom_range(0, 9) != 0) begin
      pick = $urandom_range(0, 3);
      if (pick == 0) r.index = '0;
      else if (pick == 1) r.index = IDX_W'(fill - 1);
      else r.index = IDX_W'($urandom_range(0, fill - 1));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic send_request(input req_t r, input logic known, input rsp_t rsp);
    pinned_t pin;
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
    end
    burst_left--;
    pin.known = known;
    pin.rsp = rsp;
    pinned_rsp_q.push_back(pin);
    req_if.valid <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    rsp_t    want;
    rsp_t    got;
    rsp_t    predicted;
    pinned_t pin;
    if (rst_ni) begin
      idle_cycles++;
      if (req_if.valid && req_if.ready) begin
        predicted = list_apply(req_if.payload);
        pin = pinned_rsp_q.pop_front();
        due_rsp_q.push_back(pin.known ? pin.rsp : predicted);
        accepted_reqs++;
        idle_cycles = 0;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.payload;
        idle_cycles = 0;
        if (due_rsp_q.size() == 0) begin
          report_mismatch($sformatf("response %0d with nothing pending: %h", seen_rsps, got));
        end else begin
          want = due_rsp_q.pop_front();
          if (got.read_value !== want.read_value)
            report_mismatch($sformatf("response %0d read_value %h, want %h",
                                      seen_rsps, got.read_value, want.read_value));
          if (got.error !== want.error)
            report_mismatch($sformatf("response %0d error %0d, want %0d",
                                      seen_rsps, got.error, want.error));
          if (got.count !== want.count)
            report_mismatch($sformatf("response %0d count %0d, want %0d",
                                      seen_rsps, got.count, want.count));
          if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("response %0d is_empty %b, want %b",
                                      seen_rsps, got.is_empty, want.is_empty));
        end
        seen_rsps++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d cycles with no request or response moving.", IDLE_LIMIT);
        $display("indexed_list_insert_remove regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned mode;
    int unsigned span;
    logic        holdoff_done;
    holdoff_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!holdoff_done && accepted_reqs >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        repeat (HOLDOFF_LEN) begin
          @(negedge clk_i);
          rsp_if.ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 60);
      repeat (span) begin
        @(negedge clk_i);
        if (mode == 0) rsp_if.ready <= 1'b1;
        else if (mode == 1) rsp_if.ready <= ($urandom_range(0, 3) != 0);
        else rsp_if.ready <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin
    trend_e      trend;
    int unsigned hold_left;
    req_t        r;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    rsp_if.ready = 1'b0;
    trend = TREND_GROW;
    hold_left = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int n = 0; n < N_DIRECTED; n++) begin
      send_request(directed_rows[n].req, directed_rows[n].known, directed_rows[n].rsp);
    end

    // Fill to capacity, press on the full list, drain to empty, wander, then start over.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case (trend)
        TREND_GROW: begin
          if (list_q.size() == CAPACITY) begin
            trend = TREND_FULL;
            hold_left = 8;
          end
        end
        TREND_FULL: begin
          if (hold_left == 0) trend = TREND_SHRINK;
          else hold_left--;
        end
        TREND_SHRINK: begin
          if (list_q.size() == 0) begin
            trend = TREND_MIX;
            hold_left = $urandom_range(30, 80);
          end
        end
        default: begin
          if (hold_left == 0) trend = TREND_GROW;
          else hold_left--;
        end
      endcase
      r = make_request(trend);
      send_request(r, 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    while (due_rsp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (due_rsp_q.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", due_rsp_q.size()));

    if (fail_count == 0) begin
      $display("indexed_list_insert_remove regression: pass");
    end else begin
      $display("indexed_list_insert_remove regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ilir_pkg.sv
hw/rtl/ilir_stream_if.sv
hw/rtl/ilir_cell.sv
hw/rtl/indexed_list_insert_remove.sv
sim/indexed_list_insert_remove_test.sv
